### hw/rtl/rls_pkg.sv
package rls_pkg;

  localparam int MaxLineBytes = 2048;
  localparam int MaxRows      = 256;

  localparam logic [1:0] ModePush  = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgPix    = 2'd2;

  localparam logic [11:0] ResetWidth  = 12'd512;
  localparam logic [8:0]  ResetHeight = 9'd256;
  localparam logic [2:0]  ResetPix    = 3'd1;

endpackage

### hw/rtl/rolling_line_store_core.sv
// Rolling line store core.
// Items enter on the command channel: start with mode and its payload is taken
// when busy is low. Mode push appends data_byte to the staging line; when a
// full line (width times pixel bytes) has been gathered, it is copied into the
// next ring row, one byte per cycle, and line_done is reported. Mode read
// returns one pixel of a held line, addressed by push order (zero is oldest).
// Mode query walks the new marks downward from the newest row, one row per
// cycle, and reports up to two ranges while clearing the marks it passes.
// Mode clear resets the positions, the count and all marks.
// Each item gives exactly one result, shown for one cycle with out_valid.
// A completing push copies the line through the one staging memory port; a
// read fetches one ring byte per cycle behind a two-stage address and data
// pipeline, and an out-of-range read gives its result without a ring fetch.
// Configuration writes on the cfg channel are taken when cfg_ready is high,
// which is whenever no item is at work and start is low; any known write also clears.
// Reset brings registers to 512 pixels, 256 rows, 1 byte per pixel, all empty.
// The receiver cannot stall; results are simply presented for one cycle.
module rolling_line_store_core #(
  parameter int MAX_LINE_BYTES = rls_pkg::MaxLineBytes,
  parameter int MAX_ROWS       = rls_pkg::MaxRows
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [10:0] in_column,
  input  logic [7:0]  in_row_order,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        out_valid,
  output logic        out_line_done,
  output logic        out_pixel_valid,
  output logic [31:0] out_pixel_value,
  output logic [1:0]  out_range_count,
  output logic [7:0]  out_first_start,
  output logic [7:0]  out_first_end,
  output logic [7:0]  out_second_start,
  output logic [7:0]  out_second_end,
  output logic [8:0]  out_lines_held,
  output logic [7:0]  out_next_write_row
);

  localparam int CW = $clog2(MAX_LINE_BYTES);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int FW = $clog2(MAX_LINE_BYTES + 1);
  localparam int AW = RW + CW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCopy  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;
  localparam logic [2:0] StCopyW = 3'd5;

  // The ring and the staging line live in synchronous memories.
  logic [7:0] ring_mem [MAX_ROWS * MAX_LINE_BYTES];
  logic [7:0] stage_mem [MAX_LINE_BYTES];
  logic [MAX_ROWS-1:0] marks_r;

  logic [11:0] width_cfg_r;
  logic [8:0]  height_cfg_r;
  logic [2:0]  pix_cfg_r;
  logic [2:0]  state_r;
  logic [FW-1:0] fill_r;
  logic [RW-1:0] wrow_r;
  logic [HW-1:0] held_r;

  // Effective configuration after clamping.
  logic [HW-1:0] eff_h;
  logic [2:0]    eff_pb;
  logic [12:0]   eff_w;
  logic [12:0]   w_lim;
  logic [FW+2:0] line_bytes;
  logic [RW-1:0] h_last;

  always_comb begin
    if (height_cfg_r == 9'd0) eff_h = HW'(1);
    else if ({23'd0, height_cfg_r} > 32'(MAX_ROWS)) eff_h = HW'(MAX_ROWS);
    else eff_h = HW'(height_cfg_r);
    if (pix_cfg_r == 3'd0) eff_pb = 3'd1;
    else if (pix_cfg_r > 3'd4) eff_pb = 3'd4;
    else eff_pb = pix_cfg_r;
    case (eff_pb)
      3'd1:    w_lim = 13'(MAX_LINE_BYTES);
      3'd2:    w_lim = 13'(MAX_LINE_BYTES / 2);
      3'd3:    w_lim = 13'(MAX_LINE_BYTES / 3);
      default: w_lim = 13'(MAX_LINE_BYTES / 4);
    endcase
    eff_w = (width_cfg_r == 12'd0) ? 13'd1 : {1'b0, width_cfg_r};
    if (eff_w > 13'd2048) eff_w = 13'd2048;
    if (eff_w > w_lim) eff_w = w_lim;
    if (eff_w == 13'd0) eff_w = 13'd1;
    line_bytes = (FW+3)'(eff_w * eff_pb);
    h_last = RW'(eff_h - HW'(1));
  end

  logic [RW-1:0] wrow_c;
  logic [HW-1:0] held_c;
  assign wrow_c = ({{(HW-RW){1'b0}}, wrow_r} >= eff_h) ? '0 : wrow_r;
  assign held_c = (held_r > eff_h) ? eff_h : held_r;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != StIdle);
  assign cfg_ready = (state_r == StIdle) && !start;

  // Working registers of the multi-cycle sequences.
  logic [CW:0]   cnt_r;
  logic [RW-1:0] row_r;
  logic [AW-1:0] raddr_r;
  logic [2:0]    bleft_r;
  logic [31:0]   acc_r;
  logic          second_r;
  logic [7:0]    rd_stage_r;
  logic [7:0]    rd_ring_r;
  logic          stage_we;
  logic [CW-1:0] stage_wa;
  logic [CW-1:0] stage_ra;
  logic          ring_we_r;
  logic [AW-1:0] ring_wa_r;
  logic          ring_rd_r;
  logic          ring_rd2_r;

  logic        res_line_r, res_pv_r;
  logic [1:0]  res_rc_r;
  logic [7:0]  res_fs_r, res_fe_r, res_ss_r, res_se_r;

  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[stage_wa] <= in_data_byte;
    rd_stage_r <= stage_mem[stage_ra];
    if (ring_we_r) ring_mem[ring_wa_r] <= rd_stage_r;
    rd_ring_r <= ring_mem[raddr_r];
  end

  logic [FW-1:0] fill_base;
  assign fill_base = ({3'd0, fill_r} >= line_bytes) ? '0 : fill_r;
  assign stage_we  = accept && in_mode == rls_pkg::ModePush;
  assign stage_wa  = CW'(fill_base);
  assign stage_ra  = CW'(cnt_r);

  logic [RW:0]  phys_sum;
  assign phys_sum = {1'b0, wrow_c} + (RW+1)'(in_row_order);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StIdle;
      width_cfg_r  <= rls_pkg::ResetWidth;
      height_cfg_r <= rls_pkg::ResetHeight;
      pix_cfg_r    <= rls_pkg::ResetPix;
      fill_r       <= '0;
      wrow_r       <= '0;
      held_r       <= '0;
      marks_r      <= '0;
      out_valid    <= 1'b0;
      ring_we_r    <= 1'b0;
      ring_rd_r    <= 1'b0;
      ring_rd2_r   <= 1'b0;
    end else begin
      out_valid <= (state_r == StDone);
      ring_we_r <= (state_r == StCopy);
      if (cfg_valid && cfg_ready &&
          (cfg_index == rls_pkg::CfgWidth || cfg_index == rls_pkg::CfgHeight ||
           cfg_index == rls_pkg::CfgPix)) begin
        case (cfg_index)
          rls_pkg::CfgWidth:  width_cfg_r  <= cfg_data;
          rls_pkg::CfgHeight: height_cfg_r <= cfg_data[8:0];
          default:            pix_cfg_r    <= cfg_data[2:0];
        endcase
        fill_r  <= '0;
        wrow_r  <= '0;
        held_r  <= '0;
        marks_r <= '0;
      end
      case (state_r)
        StIdle: begin
          if (accept) begin
            wrow_r <= (in_mode == rls_pkg::ModeClear) ? '0 : wrow_c;
            held_r <= (in_mode == rls_pkg::ModeClear) ? '0 : held_c;
            res_line_r <= 1'b0;
            res_pv_r   <= 1'b0;
            acc_r      <= '0;
            res_rc_r   <= 2'd0;
            res_fs_r   <= '0;
            res_fe_r   <= '0;
            res_ss_r   <= '0;
            res_se_r   <= '0;
            second_r   <= 1'b0;
            state_r    <= StDone;
            case (in_mode)
              rls_pkg::ModePush: begin
                if ({3'd0, fill_base} + (FW+3)'(1) >= line_bytes) begin
                  fill_r     <= '0;
                  cnt_r      <= '0;
                  res_line_r <= 1'b1;
                  state_r    <= StCopy;
                end else begin
                  fill_r <= fill_base + FW'(1);
                end
              end
              rls_pkg::ModeRead: begin
                if ((HW+1)'(in_row_order) < (HW+1)'(eff_h) &&
                    (HW+1)'(in_row_order) < (HW+1)'(held_c) &&
                    {2'd0, in_column} < eff_w) begin
                  if (held_c < eff_h) row_r <= RW'(in_row_order);
                  else if (phys_sum >= (RW+1)'(eff_h)) row_r <= RW'(phys_sum - (RW+1)'(eff_h));
                  else row_r <= RW'(phys_sum);
                  cnt_r      <= (CW+1)'(in_column * eff_pb);
                  bleft_r    <= eff_pb;
                  res_pv_r   <= 1'b1;
                  state_r    <= StRead;
                  ring_rd_r  <= 1'b0;
                  ring_rd2_r <= 1'b0;
                end
              end
              rls_pkg::ModeQuery: begin
                row_r   <= (wrow_c == '0) ? h_last : wrow_c - RW'(1);
                state_r <= StScan;
              end
              default: begin
                fill_r  <= '0;
                marks_r <= '0;
              end
            endcase
          end
        end
        StCopy: begin
          // Staging byte cnt is read now; it is written into the ring next cycle.
          ring_wa_r <= {wrow_r, CW'(cnt_r)};
          if ((FW+3)'(cnt_r) + (FW+3)'(1) >= line_bytes) begin
            state_r <= StCopyW;
          end else begin
            cnt_r <= cnt_r + (CW+1)'(1);
          end
        end
        StCopyW: begin
          marks_r[wrow_r] <= 1'b1;
          wrow_r  <= (wrow_r == h_last) ? '0 : wrow_r + RW'(1);
          if (held_r < eff_h) held_r <= held_r + HW'(1);
          state_r <= StDone;
        end
        StRead: begin
          // Address registered, ring byte read into rd_ring_r, then shifted into acc_r.
          raddr_r    <= {row_r, CW'(cnt_r)};
          cnt_r      <= cnt_r + (CW+1)'(1);
          ring_rd_r  <= 1'b1;
          ring_rd2_r <= ring_rd_r;
          if (ring_rd2_r) begin
            acc_r   <= {acc_r[23:0], rd_ring_r};
            bleft_r <= bleft_r - 3'd1;
            if (bleft_r == 3'd1) state_r <= StDone;
          end
        end
        StScan: begin
          if (marks_r[row_r]) begin
            marks_r[row_r] <= 1'b0;
            if (!second_r) begin
              if (res_rc_r == 2'd0) res_fe_r <= 8'(row_r);
              res_rc_r <= 2'd1;
              res_fs_r <= 8'(row_r);
            end else begin
              if (res_rc_r == 2'd1) res_se_r <= 8'(row_r);
              res_rc_r <= 2'd2;
              res_ss_r <= 8'(row_r);
            end
            if (row_r == '0) begin
              if (!second_r && wrow_r != '0) begin
                second_r <= 1'b1;
                row_r    <= h_last;
              end else begin
                state_r <= StDone;
              end
            end else begin
              row_r <= row_r - RW'(1);
            end
          end else begin
            state_r <= StDone;
          end
        end
        default: begin
          state_r <= StIdle;
        end
      endcase
    end
  end

  assign out_line_done      = res_line_r;
  assign out_pixel_valid    = res_pv_r;
  assign out_pixel_value    = acc_r;
  assign out_range_count    = res_rc_r;
  assign out_first_start    = res_fs_r;
  assign out_first_end      = res_fe_r;
  assign out_second_start   = res_ss_r;
  assign out_second_end     = res_se_r;
  assign out_lines_held     = 9'(held_r);
  assign out_next_write_row = 8'(wrow_r);

  a_no_start_when_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> held_r <= eff_h) else $error("held count above height");
  a_range_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res_rc_r != 2'd3) else $error("bad range count");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  // Register index that the block does not know; a write to it must change nothing.
  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic        line_done;
    logic        pixel_valid;
    logic [31:0] pixel_value;
    logic [1:0]  range_count;
    logic [7:0]  first_start;
    logic [7:0]  first_end;
    logic [7:0]  second_start;
    logic [7:0]  second_end;
    logic [8:0]  lines_held;
    logic [7:0]  next_write_row;
  } line_result_t;

  // One row of the directed table. A register write keeps its index in mode.
  // Rows flagged zero_result expect a result that is all zero (empty store).
  typedef struct {
    bit          is_reg;
    bit          zero_result;
    logic [1:0]  mode;
    logic [7:0]  dbyte;
    logic [10:0] col;
    logic [7:0]  row;
    logic [11:0] val;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_data_byte = '0;
  logic [10:0] in_column = '0;
  logic [7:0]  in_row_order = '0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        busy, cfg_ready, out_valid;
  logic        out_line_done, out_pixel_valid;
  logic [31:0] out_pixel_value;
  logic [1:0]  out_range_count;
  logic [7:0]  out_first_start, out_first_end, out_second_start, out_second_end;
  logic [8:0]  out_lines_held;
  logic [7:0]  out_next_write_row;

  rolling_line_store_core dut (
    .clk, .rst_n, .start, .busy,
    .in_mode, .in_data_byte, .in_column, .in_row_order,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_line_done, .out_pixel_valid, .out_pixel_value,
    .out_range_count, .out_first_start, .out_first_end,
    .out_second_start, .out_second_end, .out_lines_held, .out_next_write_row
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the store: the ring, the staging line, positions and marks.
  logic [7:0] ring_bytes [0:rls_pkg::MaxRows*rls_pkg::MaxLineBytes-1];
  logic [7:0] staged [0:rls_pkg::MaxLineBytes-1];
  bit         new_mark [0:rls_pkg::MaxRows-1];
  int         stage_fill, write_row, held_lines;
  int         reg_width, reg_height, reg_pix;

  line_result_t pending_results[$];
  bit           failed = 1'b0;
  bit           quiet = 1'b0;
  int           stall_cycles = 0;

  function automatic int pix_bytes();
    return (reg_pix < 1) ? 1 : (reg_pix > 4) ? 4 : reg_pix;
  endfunction

  function automatic int ring_rows();
    return (reg_height < 1) ? 1 : (reg_height > rls_pkg::MaxRows) ? rls_pkg::MaxRows : reg_height;
  endfunction

  function automatic int line_pixels();
    int w;
    w = reg_width;
    if (w < 1) w = 1;
    if (w > 2048) w = 2048;
    if (w > rls_pkg::MaxLineBytes / pix_bytes()) w = rls_pkg::MaxLineBytes / pix_bytes();
    return w;
  endfunction

  function automatic void empty_store();
    stage_fill = 0;
    write_row = 0;
    held_lines = 0;
    foreach (new_mark[i]) new_mark[i] = 1'b0;
  endfunction

  // Walk the new marks down from a row while they are set, clearing them.
  // Returns the lowest row reached plus one, so top+1 means nothing was marked.
  function automatic int sweep_marks(int top);
    int r;
    r = top;
    while (r >= 0 && r < rls_pkg::MaxRows && new_mark[r]) begin
      new_mark[r] = 1'b0;
      r--;
    end
    return r + 1;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [11:0] val);
    case (idx)
      rls_pkg::CfgWidth:  reg_width = int'(val);
      rls_pkg::CfgHeight: reg_height = int'(val[8:0]);
      rls_pkg::CfgPix:    reg_pix = int'(val[2:0]);
      default:            return;
    endcase
    empty_store();
  endfunction

  // Works out the one result an item causes and advances the shadow store.
  function automatic line_result_t predict_line_item(logic [1:0] m, logic [7:0] d,
                                                     logic [10:0] c, logic [7:0] ro);
    line_result_t r;
    int h, pb, w, lb, top, lo, lo2, phys, base;
    logic [31:0] v;
    r = '0;
    h = ring_rows();
    pb = pix_bytes();
    w = line_pixels();
    lb = w * pb;
    if (write_row >= h) write_row = 0;
    if (held_lines > h) held_lines = h;
    case (m)
      rls_pkg::ModePush: begin
        if (stage_fill >= lb) stage_fill = 0;
        staged[stage_fill] = d;
        stage_fill++;
        if (stage_fill >= lb) begin
          for (int k = 0; k < lb; k++)
            ring_bytes[write_row*rls_pkg::MaxLineBytes + k] = staged[k];
          new_mark[write_row] = 1'b1;
          write_row++;
          if (write_row >= h) write_row = 0;
          if (held_lines < h) held_lines++;
          stage_fill = 0;
          r.line_done = 1'b1;
        end
      end
      rls_pkg::ModeRead: begin
        if (ro < h && ro < held_lines && c < w) begin
          phys = (held_lines < h) ? ro : (write_row + ro) % h;
          base = phys * rls_pkg::MaxLineBytes + c * pb;
          v = '0;
          for (int k = 0; k < pb; k++) v = (v << 8) | ring_bytes[base + k];
          r.pixel_valid = 1'b1;
          r.pixel_value = v;
        end
      end
      rls_pkg::ModeQuery: begin
        top = (write_row == 0) ? h - 1 : write_row - 1;
        lo = sweep_marks(top);
        if (lo != top + 1) begin
          r.range_count = 2'd1;
          r.first_start = lo[7:0];
          r.first_end = top[7:0];
          // The first range ran into row zero: continue from the top of the ring.
          if (write_row != 0 && lo == 0) begin
            lo2 = sweep_marks(h - 1);
            if (lo2 != h) begin
              r.range_count = 2'd2;
              r.second_start = lo2[7:0];
              r.second_end = 8'(h - 1);
            end
          end
        end
      end
      default: empty_store();
    endcase
    r.lines_held = held_lines[8:0];
    r.next_write_row = write_row[7:0];
    return r;
  endfunction

  // Offer one item; start stays high on return so the next item can follow at once.
  task automatic send_item(logic [1:0] m, logic [7:0] d, logic [10:0] c, logic [7:0] ro,
                           bit zero_result);
    line_result_t r;
    if (!quiet && $urandom_range(99) < 12) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 12);
    end
    start <= 1'b1;
    in_mode <= m;
    in_data_byte <= d;
    in_column <= c;
    in_row_order <= ro;
    r = predict_line_item(m, d, c, ro);
    pending_results.push_back(zero_result ? line_result_t'('0) : r);
    do @(posedge clk); while (busy);
  endtask

  // Registers change only with the block idle: start low and all results in first.
  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Every result is compared with the oldest expectation still waiting.
  always @(posedge clk) begin
    line_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item waiting for it", $time);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        check_field("line_done", 32'(e.line_done), 32'(out_line_done));
        check_field("pixel_valid", 32'(e.pixel_valid), 32'(out_pixel_valid));
        check_field("pixel_value", e.pixel_value, out_pixel_value);
        check_field("range_count", 32'(e.range_count), 32'(out_range_count));
        check_field("first_start", 32'(e.first_start), 32'(out_first_start));
        check_field("first_end", 32'(e.first_end), 32'(out_first_end));
        check_field("second_start", 32'(e.second_start), 32'(out_second_start));
        check_field("second_end", 32'(e.second_end), 32'(out_second_end));
        check_field("lines_held", 32'(e.lines_held), 32'(out_lines_held));
        check_field("next_write_row", 32'(e.next_write_row), 32'(out_next_write_row));
      end
    end
  end

  // The longest correct wait is a full 2048 byte line copy, far below the limit.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("tb: FAIL");
      $finish;
    end
  end

  step_t directed [0:26];
  int    phase_cfg [0:9][0:3];

  initial begin
    int m;
    logic [7:0] ro;
    logic [10:0] c;

    // The first rows run on the reset settings, where a line is 512 bytes long,
    // so nothing can be held yet and every result is plain zero.
    directed = '{
      '{0, 1, rls_pkg::ModeRead,  8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 1, rls_pkg::ModeQuery, 8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 1, rls_pkg::ModePush,  8'hff, 11'd0,    8'd0,   12'd0},
      '{0, 1, rls_pkg::ModeClear, 8'h00, 11'd0,    8'd0,   12'd0},
      // One pixel of two bytes per line and three rows: two bytes make a line.
      '{1, 0, rls_pkg::CfgWidth,  8'h00, 11'd0,    8'd0,   12'd1},
      '{1, 0, rls_pkg::CfgHeight, 8'h00, 11'd0,    8'd0,   12'd3},
      '{1, 0, rls_pkg::CfgPix,    8'h00, 11'd0,    8'd0,   12'd2},
      '{0, 0, rls_pkg::ModePush,  8'hff, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'h80, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'h01, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'h7f, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'hfe, 11'd0,    8'd0,   12'd0},
      // This line wraps the ring; the query then finds a range at row zero
      // and a second range at the top of the ring.
      '{0, 0, rls_pkg::ModePush,  8'ha5, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'h5a, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModeQuery, 8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModeQuery, 8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModeRead,  8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModeRead,  8'h00, 11'd0,    8'd2,   12'd0},
      '{0, 0, rls_pkg::ModeRead,  8'h00, 11'd0,    8'd3,   12'd0},
      '{0, 0, rls_pkg::ModeRead,  8'h00, 11'd2047, 8'd0,   12'd0},
      '{0, 0, rls_pkg::ModeRead,  8'h00, 11'd0,    8'd255, 12'd0},
      '{0, 0, rls_pkg::ModeClear, 8'h00, 11'd0,    8'd0,   12'd0},
      '{0, 1, rls_pkg::ModeRead,  8'h00, 11'd0,    8'd0,   12'd0},
      // Four byte pixels: the first byte lands in the top of the value.
      '{1, 0, rls_pkg::CfgPix,    8'h00, 11'd0,    8'd0,   12'd4},
      '{0, 0, rls_pkg::ModePush,  8'hc3, 11'd0,    8'd0,   12'd0},
      '{0, 0, rls_pkg::ModePush,  8'h3c, 11'd0,    8'd0,   12'd0}
    };

    // Random phases: width, height, pixel bytes and item count. Out of range
    // values are clamped by the block, so zero and all-ones settings appear here.
    phase_cfg = '{
      '{3, 4, 1, 70}, '{0, 0, 0, 40}, '{2, 256, 2, 55}, '{5, 511, 7, 50},
      '{4095, 2, 4, 6}, '{1, 2, 3, 60}, '{6, 3, 1, 70}, '{2, 5, 2, 75},
      '{1, 7, 1, 80}, '{4, 1, 4, 35}
    };

    reg_width = int'(rls_pkg::ResetWidth);
    reg_height = int'(rls_pkg::ResetHeight);
    reg_pix = int'(rls_pkg::ResetPix);
    empty_store();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_reg)
        write_reg(directed[i].mode, directed[i].val);
      else
        send_item(directed[i].mode, directed[i].dbyte, directed[i].col, directed[i].row,
                  directed[i].zero_result);
    end
    // Finish the four byte pixel line and read it back.
    send_item(rls_pkg::ModePush, 8'h01, 11'd0, 8'd0, 1'b0);
    send_item(rls_pkg::ModePush, 8'hfe, 11'd0, 8'd0, 1'b0);
    send_item(rls_pkg::ModeRead, 8'h00, 11'd0, 8'd0, 1'b0);
    write_reg(CfgSpare, 12'hfff);

    for (int p = 0; p < 10; p++) begin
      write_reg(rls_pkg::CfgWidth, 12'(phase_cfg[p][0]));
      write_reg(rls_pkg::CfgHeight, 12'(phase_cfg[p][1]));
      write_reg(rls_pkg::CfgPix, 12'(phase_cfg[p][2]));
      // Phases six and seven send items without the random idle gaps before each item.
      quiet = (p == 6 || p == 7);
      for (int n = 0; n < phase_cfg[p][3]; n++) begin
        m = $urandom_range(99);
        c = 11'($urandom);
        ro = 8'($urandom);
        // Mostly aim reads at held lines and valid columns, sometimes one past.
        if ($urandom_range(99) < 80) begin
          ro = 8'($urandom_range(held_lines));
          c = 11'($urandom_range(line_pixels()));
        end
        if (m < 62)
          send_item(rls_pkg::ModePush, 8'($urandom), 11'($urandom), 8'($urandom), 1'b0);
        else if (m < 87)
          send_item(rls_pkg::ModeRead, 8'($urandom), c, ro, 1'b0);
        else if (m < 97)
          send_item(rls_pkg::ModeQuery, 8'($urandom), 11'($urandom), 8'($urandom), 1'b0);
        else
          send_item(rls_pkg::ModeClear, 8'($urandom), 11'($urandom), 8'($urandom), 1'b0);
        // Now and then the sender holds off until everything has come back.
        if ($urandom_range(99) < 2) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
